// ===== design/rc4_pkg.sv =====
package rc4_pkg;

   localparam int unsigned DATA_W            = 8;
   localparam int unsigned SBOX_DEPTH        = 256;
   localparam int unsigned KEY_BYTES_MAX     = 16;
   localparam int unsigned KEY_BYTES_DEFAULT = 16;
   localparam int unsigned KIDX_W            = 4;
   localparam int unsigned KEY_W             = KEY_BYTES_MAX * DATA_W;
   localparam int unsigned CSR_IDX_W         = 2;
   localparam int unsigned CSR_DATA_W        = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HI = 2'd1;

   // datapath operations, one per controller step
   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_FILL   = 4'd1,
      OP_K_RD_I = 4'd2,
      OP_K_RD_J = 4'd3,
      OP_K_WR_J = 4'd4,
      OP_K_WR_I = 4'd5,
      OP_G_RD_I = 4'd6,
      OP_G_RD_J = 4'd7,
      OP_G_WR_I = 4'd8,
      OP_G_WR_J = 4'd9,
      OP_G_RD_T = 4'd10,
      OP_G_KS   = 4'd11
   } rc4_op_type;

   typedef struct packed {
      rc4_op_type op;
      logic       cap_in;
      logic       out_load;
   } rc4_cmd_type;

endpackage

// ===== design/rc4_if.sv =====
interface rc4_req_if;
   logic                      valid;
   logic                      ready;
   logic [rc4_pkg::DATA_W-1:0] data_byte;
   logic                      last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rc4_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rc4_pkg::DATA_W-1:0] out_byte;
   logic                      out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface rc4_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rc4_pkg::CSR_IDX_W-1:0]  index;
   logic [rc4_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/rc4_datapath.sv =====
module rc4_datapath #(
   parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rc4_pkg::rc4_cmd_type           cmd,
   output logic                           cnt_last,
   input  logic [rc4_pkg::DATA_W-1:0]     req_data,
   input  logic                           req_last,
   input  logic                           csr_we,
   input  logic [rc4_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [rc4_pkg::DATA_W-1:0]     out_byte,
   output logic                           out_last
);

   localparam int unsigned DW = rc4_pkg::DATA_W;
   localparam int unsigned KW = rc4_pkg::KIDX_W;

   logic [DW-1:0] sbox_mem [rc4_pkg::SBOX_DEPTH];
   logic [DW-1:0] rdata_ff;

   logic [DW-1:0] cnt_ff,  cnt_in;
   logic [KW-1:0] kidx_ff, kidx_in;
   logic [DW-1:0] i_ff,    i_in;
   logic [DW-1:0] j_ff,    j_in;
   logic [DW-1:0] si_ff,   si_in;
   logic [DW-1:0] sj_ff,   sj_in;
   logic [DW-1:0] ks_ff,   ks_in;
   logic [DW-1:0] data_ff, data_in;
   logic          last_ff, last_in;
   logic [DW-1:0] obyte_ff, obyte_in;
   logic          olast_ff, olast_in;
   logic [rc4_pkg::CSR_DATA_W-1:0] key_lo_ff, key_lo_in;
   logic [rc4_pkg::CSR_DATA_W-1:0] key_hi_ff, key_hi_in;

   logic [rc4_pkg::KEY_W-1:0] key_w;
   logic [DW-1:0] key_byte;
   logic [DW-1:0] jsum;
   logic [DW-1:0] jkey;
   logic [DW-1:0] i_next;
   logic [DW-1:0] t_addr;
   logic [KW-1:0] kidx_next;
   logic          mem_we;
   logic [DW-1:0] waddr;
   logic [DW-1:0] wdata;
   logic [DW-1:0] raddr;

   assign key_w    = {key_hi_ff, key_lo_ff};
   assign key_byte = key_w[{kidx_ff, 3'b000} +: DW];
   assign jsum     = DW'(j_ff + rdata_ff);
   assign jkey     = DW'(jsum + key_byte);
   assign i_next   = DW'(i_ff + 1'b1);
   assign t_addr   = DW'(si_ff + sj_ff);
   assign cnt_last = (cnt_ff == {DW{1'b1}});
   assign kidx_next = (kidx_ff == KW'(KEY_BYTES - 1)) ? '0 : KW'(kidx_ff + 1'b1);

   // memory port steering
   always_comb begin
      mem_we = 1'b0;
      waddr  = cnt_ff;
      wdata  = cnt_ff;
      raddr  = cnt_ff;
      unique case (cmd.op)
         rc4_pkg::OP_FILL:   mem_we = 1'b1;
         rc4_pkg::OP_K_RD_J: raddr = jkey;
         rc4_pkg::OP_K_WR_J: begin
            mem_we = 1'b1;
            waddr  = j_ff;
            wdata  = si_ff;
         end
         rc4_pkg::OP_K_WR_I: begin
            mem_we = 1'b1;
            wdata  = sj_ff;
         end
         rc4_pkg::OP_G_RD_I: raddr = i_next;
         rc4_pkg::OP_G_RD_J: raddr = jsum;
         rc4_pkg::OP_G_WR_I: begin
            mem_we = 1'b1;
            waddr  = i_ff;
            wdata  = rdata_ff;
         end
         rc4_pkg::OP_G_WR_J: begin
            mem_we = 1'b1;
            waddr  = j_ff;
            wdata  = si_ff;
         end
         rc4_pkg::OP_G_RD_T: raddr = t_addr;
         default: ;
      endcase
   end

   always_comb begin
      cnt_in   = cnt_ff;
      kidx_in  = kidx_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      si_in    = si_ff;
      sj_in    = sj_ff;
      ks_in    = ks_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      obyte_in = obyte_ff;
      olast_in = olast_ff;
      key_lo_in = key_lo_ff;
      key_hi_in = key_hi_ff;

      if (csr_we && csr_index == rc4_pkg::CSR_KEY_LO) key_lo_in = csr_data;
      if (csr_we && csr_index == rc4_pkg::CSR_KEY_HI) key_hi_in = csr_data;

      if (cmd.cap_in) begin
         data_in = req_data;
         last_in = req_last;
      end
      if (cmd.out_load) begin
         obyte_in = data_ff ^ ks_ff;
         olast_in = last_ff;
      end

      unique case (cmd.op)
         rc4_pkg::OP_FILL: begin
            cnt_in  = DW'(cnt_ff + 1'b1);
            kidx_in = '0;
            i_in    = '0;
            j_in    = '0;
         end
         rc4_pkg::OP_K_RD_J: begin
            j_in  = jkey;
            si_in = rdata_ff;
         end
         rc4_pkg::OP_K_WR_J: sj_in = rdata_ff;
         rc4_pkg::OP_K_WR_I: begin
            cnt_in  = DW'(cnt_ff + 1'b1);
            kidx_in = kidx_next;
            if (cnt_last) j_in = '0;
         end
         rc4_pkg::OP_G_RD_I: i_in = i_next;
         rc4_pkg::OP_G_RD_J: begin
            j_in  = jsum;
            si_in = rdata_ff;
         end
         rc4_pkg::OP_G_WR_I: sj_in = rdata_ff;
         rc4_pkg::OP_G_KS:   ks_in = rdata_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) sbox_mem[waddr] <= wdata;
      rdata_ff <= sbox_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         kidx_ff   <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         key_lo_ff <= '0;
         key_hi_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         kidx_ff   <= kidx_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         key_lo_ff <= key_lo_in;
         key_hi_ff <= key_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff    <= si_in;
      sj_ff    <= sj_in;
      ks_ff    <= ks_in;
      data_ff  <= data_in;
      last_ff  <= last_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end

   assign out_byte = obyte_ff;
   assign out_last = olast_ff;

endmodule

// ===== design/rc4_ctrl.sv =====
module rc4_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 cnt_last,
   output rc4_pkg::rc4_cmd_type cmd
);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_FILL   = 13'b0000000000010,
      ST_K_RD_I = 13'b0000000000100,
      ST_K_RD_J = 13'b0000000001000,
      ST_K_WR_J = 13'b0000000010000,
      ST_K_WR_I = 13'b0000000100000,
      ST_G_RD_I = 13'b0000001000000,
      ST_G_RD_J = 13'b0000010000000,
      ST_G_WR_I = 13'b0000100000000,
      ST_G_WR_J = 13'b0001000000000,
      ST_G_RD_T = 13'b0010000000000,
      ST_G_KS   = 13'b0100000000000,
      ST_G_OUT  = 13'b1000000000000
   } rc4_state_type;

   rc4_state_type state_ff, state_in;
   logic          need_ff,  need_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      need_in      = need_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = rc4_pkg::OP_NONE;
      cmd.cap_in   = 1'b0;
      cmd.out_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.cap_in = 1'b1;
               need_in    = req_last;
               state_in   = need_ff ? ST_FILL : ST_G_RD_I;
            end
         end
         ST_FILL: begin
            cmd.op = rc4_pkg::OP_FILL;
            if (cnt_last) state_in = ST_K_RD_I;
         end
         ST_K_RD_I: begin
            cmd.op   = rc4_pkg::OP_K_RD_I;
            state_in = ST_K_RD_J;
         end
         ST_K_RD_J: begin
            cmd.op   = rc4_pkg::OP_K_RD_J;
            state_in = ST_K_WR_J;
         end
         ST_K_WR_J: begin
            cmd.op   = rc4_pkg::OP_K_WR_J;
            state_in = ST_K_WR_I;
         end
         ST_K_WR_I: begin
            cmd.op   = rc4_pkg::OP_K_WR_I;
            state_in = cnt_last ? ST_G_RD_I : ST_K_RD_I;
         end
         ST_G_RD_I: begin
            cmd.op   = rc4_pkg::OP_G_RD_I;
            state_in = ST_G_RD_J;
         end
         ST_G_RD_J: begin
            cmd.op   = rc4_pkg::OP_G_RD_J;
            state_in = ST_G_WR_I;
         end
         ST_G_WR_I: begin
            cmd.op   = rc4_pkg::OP_G_WR_I;
            state_in = ST_G_WR_J;
         end
         ST_G_WR_J: begin
            cmd.op   = rc4_pkg::OP_G_WR_J;
            state_in = ST_G_RD_T;
         end
         ST_G_RD_T: begin
            cmd.op   = rc4_pkg::OP_G_RD_T;
            state_in = ST_G_KS;
         end
         ST_G_KS: begin
            cmd.op   = rc4_pkg::OP_G_KS;
            state_in = ST_G_OUT;
         end
         ST_G_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         need_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         need_ff      <= need_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== design/rc4_stream_cipher.sv =====
// RC4 stream cipher, byte at a time.
// Channels: req_bus takes one request per message byte (data_byte, last_byte);
// rsp_bus returns out_byte = data_byte XOR keystream and out_last, one result
// per request, in order. csr_bus writes the key: index 0 is key_lo (bytes 0..7),
// index 1 is key_hi (bytes 8..15); other indexes are dropped. csr_bus is always
// ready; write the key only while no request is in flight.
// Flow: a request is taken only while the controller idles. The first byte
// of a message first runs the key schedule: fill the S-box with the identity,
// then swap each entry with S[j]. Each byte then runs the generator steps up
// to the output register load before the next request can be taken. The
// steps run one by one on the single S-box memory: one read and one write per
// cycle, with each access depending on the data of the one before.
// Reset: clears the key, both indices and the output valid, and marks that the
// next byte starts a message. S-box contents are not cleared; the schedule
// rewrites them before use.
// Stall: a finished result sits in the output register; the next request is
// accepted and processed, and its result waits until rsp_bus.ready drains it.
module rc4_stream_cipher #(
   parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   rc4_req_if.sink   req_bus,
   rc4_rsp_if.source rsp_bus,
   rc4_csr_if.sink   csr_bus
);

   rc4_pkg::rc4_cmd_type cmd;
   logic                 cnt_last;

   // key registers never stall a write
   assign csr_bus.ready = 1'b1;

   // sequencer: schedule and per-byte generator steps
   rc4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_byte),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cnt_last  (cnt_last),
      .cmd       (cmd)
   );

   // S-box memory, indices, key and output register
   rc4_datapath #(
      .KEY_BYTES (KEY_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cnt_last  (cnt_last),
      .req_data  (req_bus.data_byte),
      .req_last  (req_bus.last_byte),
      .csr_we    (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .out_byte  (rsp_bus.out_byte),
      .out_last  (rsp_bus.out_last)
   );

endmodule

// ===== test/rc4_stream_cipher_check.sv =====
`timescale 1ns / 1ps
module rc4_stream_cipher_check #(
   parameter int unsigned KEY_LEN = rc4_pkg::KEY_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rc4_req_if          req_bus,
   rc4_rsp_if          rsp_bus,
   rc4_csr_if          csr_bus,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam int unsigned DW = rc4_pkg::DATA_W;

   typedef struct packed {
      logic [DW-1:0] out_byte;
      logic          out_last;
   } cipher_out_type;

   logic [rc4_pkg::CSR_DATA_W-1:0] key_lo_q;
   logic [rc4_pkg::CSR_DATA_W-1:0] key_hi_q;
   logic [DW-1:0]                  perm [rc4_pkg::SBOX_DEPTH];
   logic [DW-1:0]                  ptr_i;
   logic [DW-1:0]                  ptr_j;
   logic                           rekey_due;
   cipher_out_type                 cipher_q [$];
   int unsigned                    fails = 0;

   // key bytes repeat every KEY_LEN entries
   function automatic logic [DW-1:0] key_byte_at(int unsigned n);
      int unsigned                    k;
      logic [rc4_pkg::CSR_DATA_W-1:0] word;
      k    = n % KEY_LEN;
      word = (k < 8) ? key_lo_q : key_hi_q;
      return word[(k % 8) * DW +: DW];
   endfunction

   task automatic run_key_schedule();
      logic [DW-1:0] j;
      logic [DW-1:0] t;
      j = '0;
      for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++)
         perm[n] = DW'(n);
      for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) begin
         j       = j + perm[n] + key_byte_at(n);
         t       = perm[n];
         perm[n] = perm[j];
         perm[j] = t;
      end
      ptr_i = '0;
      ptr_j = '0;
   endtask

   task automatic crypt_byte(input logic [DW-1:0] data, input logic last,
                             output cipher_out_type res);
      logic [DW-1:0] t;
      if (rekey_due) begin
         run_key_schedule();
         rekey_due = 1'b0;
      end
      ptr_i       = ptr_i + 1'b1;
      ptr_j       = ptr_j + perm[ptr_i];
      t           = perm[ptr_i];
      perm[ptr_i] = perm[ptr_j];
      perm[ptr_j] = t;
      t            = perm[ptr_i] + perm[ptr_j];
      res.out_byte = data ^ perm[t];
      res.out_last = last;
      if (last)
         rekey_due = 1'b1;
   endtask

   always @(posedge clock) begin
      cipher_out_type want;
      if (reset) begin
         key_lo_q  = '0;
         key_hi_q  = '0;
         ptr_i     = '0;
         ptr_j     = '0;
         rekey_due = 1'b1;
         cipher_q.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               rc4_pkg::CSR_KEY_LO: key_lo_q = csr_bus.data;
               rc4_pkg::CSR_KEY_HI: key_hi_q = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            crypt_byte(req_bus.data_byte, req_bus.last_byte, want);
            cipher_q.push_back(want);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (cipher_q.size() == 0) begin
               $display("%0t: stray result, expected none, got out_byte %02h out_last %0b",
                        $time, rsp_bus.out_byte, rsp_bus.out_last);
               fails++;
            end else begin
               want = cipher_q.pop_front();
               if (rsp_bus.out_byte !== want.out_byte) begin
                  $display("%0t: out_byte expected %02h, got %02h",
                           $time, want.out_byte, rsp_bus.out_byte);
                  fails++;
               end
               if (rsp_bus.out_last !== want.out_last) begin
                  $display("%0t: out_last expected %0b, got %0b",
                           $time, want.out_last, rsp_bus.out_last);
                  fails++;
               end
            end
         end
      end
      pending    <= cipher_q.size();
      fail_count <= fails;
   end

endmodule

// ===== test/rc4_stream_cipher_tb.sv =====
`timescale 1ns / 1ps
module rc4_stream_cipher_tb;

   localparam int unsigned KEY_LEN      = rc4_pkg::KEY_BYTES_DEFAULT;
   localparam int unsigned DW           = rc4_pkg::DATA_W;
   localparam int unsigned RANDOM_BYTES = 1700;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned TAIL_CYCLES  = 16;
   // worst case is a fresh key schedule on every byte plus both sides idling
   // the longest random gap; allow several times that
   localparam int unsigned TIMEOUT_NS   = 120_000_000;

   // write indexes the block does not decode
   localparam logic [rc4_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rc4_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending;

   // sender and receiver switch between random idling and stretches of none
   bit          req_calm;
   bit          rsp_calm;
   int unsigned req_count;

   rc4_req_if req_bus ();
   rc4_rsp_if rsp_bus ();
   rc4_csr_if csr_bus ();

   rc4_stream_cipher #(.KEY_BYTES(KEY_LEN)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rc4_stream_cipher_check #(.KEY_LEN(KEY_LEN)) stream_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Offer one request. Valid stays high after the handshake so that a
   // back-to-back request needs no drop; call req_quiet before any pause.
   task automatic send_byte(input logic [DW-1:0] data, input logic last);
      int unsigned gap;
      if (req_count % 48 == 0)
         req_calm = ($urandom_range(0, 3) == 0);
      gap = req_calm ? 0 : $urandom_range(0, 10);
      req_count++;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.data_byte = data;
      req_bus.last_byte = last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic req_quiet();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic wait_drained();
      req_quiet();
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [rc4_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rc4_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Receiver: random stalls per result, plus a few long hold-offs that
   // back the block up while the sender keeps offering.
   initial begin
      int unsigned gap;
      int unsigned got;
      rsp_bus.ready = 1'b0;
      got = 0;
      wait (!reset);
      forever begin
         if (got % 48 == 0)
            rsp_calm = ($urandom_range(0, 3) == 0);
         gap = rsp_calm ? 0 : $urandom_range(0, 10);
         repeat (gap) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got++;
         if (got == 60 || got == 900 || got == 1400) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
      end
   end

   // Stimulus: directed messages first, then random key phases.
   initial begin
      logic [rc4_pkg::CSR_DATA_W-1:0] lo;
      logic [rc4_pkg::CSR_DATA_W-1:0] hi;
      int unsigned                    sent;
      int unsigned                    phase_len;
      int unsigned                    msg_left;
      int unsigned                    pick;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = rc4_pkg::CSR_KEY_LO;
      csr_bus.data      = '0;
      req_count         = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset key (all zero): data extremes in a three-byte message
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
      wait_drained();

      // all-ones key, single-byte message
      csr_write(rc4_pkg::CSR_KEY_LO, '1);
      csr_write(rc4_pkg::CSR_KEY_HI, '1);
      send_byte(8'hFF, 1'b1);
      wait_drained();

      // writes to undecoded indexes must leave the key alone; open a message
      csr_write(CSR_SPARE_2, 64'h0123_4567_89AB_CDEF);
      csr_write(CSR_SPARE_3, 64'hFEDC_BA98_7654_3210);
      send_byte(8'h00, 1'b0);
      wait_drained();

      // rekey in the middle of a message: the open message keeps the old key
      csr_write(rc4_pkg::CSR_KEY_LO, 64'h0706_0504_0302_0100);
      csr_write(rc4_pkg::CSR_KEY_HI, 64'h0F0E_0D0C_0B0A_0908);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b1);
      // next message schedules the new key
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'hF0, 1'b1);
      wait_drained();

      // alternating key bits
      csr_write(rc4_pkg::CSR_KEY_LO, {32{2'b10}});
      csr_write(rc4_pkg::CSR_KEY_HI, {32{2'b01}});
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b1);
      wait_drained();

      // back to the all-zero key
      csr_write(rc4_pkg::CSR_KEY_LO, '0);
      csr_write(rc4_pkg::CSR_KEY_HI, '0);
      send_byte(8'h96, 1'b0);
      send_byte(8'h69, 1'b1);
      wait_drained();

      // Random phases: new key setting per phase, then a run of messages.
      // A phase may end inside a message, so the key often changes mid-message.
      sent     = 0;
      msg_left = 0;
      while (sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 7);
         lo   = {$urandom, $urandom};
         hi   = {$urandom, $urandom};
         if (pick == 0) begin
            lo = '0;
            hi = '0;
         end else if (pick == 1) begin
            lo = '1;
            hi = '1;
         end
         // pick 2 touches only the low word, pick 3 only the high word
         if (pick != 3)
            csr_write(rc4_pkg::CSR_KEY_LO, lo);
         if (pick != 2)
            csr_write(rc4_pkg::CSR_KEY_HI, hi);
         if (pick == 4)
            csr_write($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, {$urandom, $urandom});

         phase_len = $urandom_range(60, 250);
         if (phase_len > RANDOM_BYTES - sent)
            phase_len = RANDOM_BYTES - sent;
         repeat (phase_len) begin
            // mostly short messages, now and then a long one
            if (msg_left == 0)
               msg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                      : $urandom_range(1, 40);
            send_byte(DW'($urandom_range(0, 255)), msg_left == 1);
            msg_left--;
            sent++;
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== rc4_stream_cipher.f =====
design/rc4_pkg.sv
design/rc4_if.sv
design/rc4_datapath.sv
design/rc4_ctrl.sv
design/rc4_stream_cipher.sv
test/rc4_stream_cipher_check.sv
test/rc4_stream_cipher_tb.sv
